### hdl/asa_pkg.sv
// asa_pkg: shared codes and types of the address slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package asa_pkg;

  // request operations
  localparam logic [1:0] OP_ASSIGN  = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_FLUSH   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_REUSED   = 3'd0;
  localparam logic [2:0] ST_FREE     = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_LOST     = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;
  localparam logic [2:0] ST_UNMAPPED = 3'd6;
  localparam logic [2:0] ST_REFS_FULL = 3'd7;

  localparam int unsigned SPACE_W  = 16;
  localparam int unsigned START_W  = 48;
  localparam int unsigned LENGTH_W = 49;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CODE_W   = 6;

  // lock region width code = ceil(log2(pages)) + REGION_OFFSET
  localparam logic [WORD_W-1:0] REGION_OFFSET = 64'd11;

  typedef struct packed {
    logic              busy;
    logic [CODE_W-1:0] code;
  } log_stat_t;

endpackage

`default_nettype wire

### hdl/address_slot_allocator.sv
// address_slot_allocator: top level; request sequencer scanning the slot table.
// Depends on asa_pkg, asa_slot_table, asa_log_unit.
//
// Usage: drive in_* with start high; the request is taken at the edge where busy
// is low. busy stays high until the result is formed. The result appears on
// out_* for exactly one cycle with out_valid high; the receiver cannot stall it
// and must take it then. busy drops in the same cycle as out_valid, so the next
// request can be taken while the result is shown.
// States from accept to out_valid:
//   job finished, or assign of a lost space: straight to S_FIN
//   assign, release: S_SCAN over every slot (one slot compared per cycle), then S_FIN
//   flush: S_SCAN, with the one-bit-per-cycle log2 unit running beside it to find
//   L = bit length of pages-1 (L <= 37); then S_WAIT until the log2 unit is idle,
//   and S_FIN, which samples the log2 unit after the scan.
// One request is in flight at a time; the next is taken only after S_FIN.
// Reset (rst_n low, synchronous) empties every slot and returns to idle; no
// result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module address_slot_allocator
  import asa_pkg::*;
#(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned PAGE_BITS = 12,
  parameter int unsigned REF_BITS  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [1:0]          in_operation,
  input  wire logic [SPACE_W-1:0]  in_space_id,
  input  wire logic                in_space_lost,
  input  wire logic [2:0]          in_slot_in,
  input  wire logic [START_W-1:0]  in_range_start,
  input  wire logic [LENGTH_W-1:0] in_range_length,
  input  wire logic [WORD_W-1:0]   in_table_entry,
  output      logic                out_valid,
  output      logic [2:0]          out_status,
  output      logic [2:0]          out_slot_out,
  output      logic                out_write_table,
  output      logic                out_invalidate_old,
  output      logic [WORD_W-1:0]   out_table_word,
  output      logic [WORD_W-1:0]   out_lock_region,
  output      logic [7:0]          out_slot_mask
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EXT_W  = IDX_W + 3;
  localparam int unsigned MASK_W = SLOTS + 8;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;

  // latched request
  logic [1:0]          op_r;
  logic [SPACE_W-1:0]  id_r;
  logic                lost_r;
  logic [2:0]          sin_r;
  logic [START_W-1:0]  rstart_r;
  logic [WORD_W-1:0]   tword_r;

  // scan results
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    match_idx_r, match_idx_nxt;
  logic [REF_BITS-1:0] match_refs_r, match_refs_nxt;
  logic                free_r, free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic                zero_r, zero_nxt;
  logic [IDX_W-1:0]    zero_idx_r, zero_idx_nxt;
  logic [SLOTS-1:0]    mask_r, mask_nxt;

  // result registers
  logic                ovalid_r;
  logic [2:0]          ostatus_r, ostatus_nxt;
  logic [IDX_W-1:0]    oslot_r, oslot_nxt;
  logic                owr_r, owr_nxt;
  logic                oinv_r, oinv_nxt;
  logic [WORD_W-1:0]   otword_r, otword_nxt;
  logic [WORD_W-1:0]   olock_r, olock_nxt;
  logic [SLOTS-1:0]    omask_r, omask_nxt;

  logic                accept;
  logic [EXT_W-1:0]    sin_ext;
  logic [IDX_W-1:0]    sin_idx;
  logic                sin_ok;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_valid;
  logic [SPACE_W-1:0]  rd_space;
  logic [REF_BITS-1:0] rd_refs;
  logic                hit;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic                wr_valid;
  logic [SPACE_W-1:0]  wr_space;
  logic [REF_BITS-1:0] wr_refs;
  log_stat_t           log_stat;
  logic [EXT_W-1:0]    slot_ext;
  logic [MASK_W-1:0]   mask_ext;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign sin_ext = EXT_W'(sin_r);
  assign sin_idx = sin_ext[IDX_W-1:0];
  assign sin_ok  = (sin_ext < EXT_W'(SLOTS));
  assign rd_idx  = (op_r == OP_FINISH) ? sin_idx : cnt_r;
  assign hit     = rd_valid && (rd_space == id_r);

  asa_slot_table #(
    .SLOTS    (SLOTS),
    .IDX_W    (IDX_W),
    .REF_BITS (REF_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_space (rd_space),
    .rd_refs  (rd_refs),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_valid (wr_valid),
    .wr_space (wr_space),
    .wr_refs  (wr_refs)
  );

  asa_log_unit #(
    .PAGE_BITS (PAGE_BITS)
  ) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept && (in_operation == OP_FLUSH)),
    .length (in_range_length),
    .stat   (log_stat)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_refs_nxt = match_refs_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    zero_nxt       = zero_r;
    zero_idx_nxt   = zero_idx_r;
    mask_nxt       = mask_r;
    ostatus_nxt    = ostatus_r;
    oslot_nxt      = oslot_r;
    owr_nxt        = owr_r;
    oinv_nxt       = oinv_r;
    otword_nxt     = otword_r;
    olock_nxt      = olock_r;
    omask_nxt      = omask_r;
    wr_en          = 1'b0;
    wr_idx         = cnt_r;
    wr_valid       = 1'b0;
    wr_space       = '0;
    wr_refs        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          zero_nxt  = 1'b0;
          mask_nxt  = '0;
          if (in_operation == OP_FINISH ||
              (in_operation == OP_ASSIGN && in_space_lost)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit && !found_r) begin
          found_nxt      = 1'b1;
          match_idx_nxt  = cnt_r;
          match_refs_nxt = rd_refs;
        end
        if (!rd_valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r;
        end
        if (rd_refs == '0 && !zero_r) begin
          zero_nxt     = 1'b1;
          zero_idx_nxt = cnt_r;
        end
        // release clears matching slots as the scan passes them
        if (op_r == OP_RELEASE && hit) begin
          wr_en           = 1'b1;
          mask_nxt[cnt_r] = 1'b1;
        end
        if (cnt_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = (op_r == OP_FLUSH) ? S_WAIT : S_FIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end

      S_WAIT: begin
        if (!log_stat.busy) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        state_nxt  = S_IDLE;
        ostatus_nxt = ST_DONE;
        oslot_nxt  = '0;
        owr_nxt    = 1'b0;
        oinv_nxt   = 1'b0;
        otword_nxt = '0;
        olock_nxt  = '0;
        omask_nxt  = '0;
        wr_space   = id_r;
        wr_valid   = 1'b1;
        wr_refs    = REF_ONE;
        case (op_r)
          OP_ASSIGN: begin
            if (lost_r) begin
              ostatus_nxt = ST_LOST;
            end else if (found_r) begin
              oslot_nxt = match_idx_r;
              if (match_refs_r == REF_MAX) begin
                ostatus_nxt = ST_REFS_FULL;
              end else begin
                ostatus_nxt = ST_REUSED;
                wr_en       = 1'b1;
                wr_idx      = match_idx_r;
                wr_refs     = match_refs_r + REF_ONE;
              end
            end else if (free_r || zero_r) begin
              ostatus_nxt = free_r ? ST_FREE : ST_EVICTED;
              oinv_nxt    = !free_r;
              oslot_nxt   = free_r ? free_idx_r : zero_idx_r;
              owr_nxt     = 1'b1;
              otword_nxt  = tword_r;
              wr_en       = 1'b1;
              wr_idx      = free_r ? free_idx_r : zero_idx_r;
            end else begin
              ostatus_nxt = ST_NONE;
            end
          end
          OP_FINISH: begin
            oslot_nxt = '0;
            if (sin_ok && rd_refs != '0) begin
              ostatus_nxt = ST_DONE;
              wr_en       = 1'b1;
              wr_idx      = sin_idx;
              wr_valid    = rd_valid;
              wr_space    = rd_space;
              wr_refs     = rd_refs - REF_ONE;
            end else begin
              ostatus_nxt = ST_UNMAPPED;
            end
          end
          OP_RELEASE: begin
            ostatus_nxt = ST_DONE;
            omask_nxt   = mask_r;
          end
          OP_FLUSH: begin
            if (found_r) begin
              ostatus_nxt = ST_DONE;
              oslot_nxt   = match_idx_r;
              olock_nxt   = WORD_W'(rstart_r) |
                            (WORD_W'(log_stat.code) + REGION_OFFSET);
            end else begin
              ostatus_nxt = ST_UNMAPPED;
            end
          end
          default: begin
            ostatus_nxt = ST_UNMAPPED;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= (state_r == S_FIN);
    end
    if (accept) begin
      op_r     <= in_operation;
      id_r     <= in_space_id;
      lost_r   <= in_space_lost;
      sin_r    <= in_slot_in;
      rstart_r <= in_range_start;
      tword_r  <= in_table_entry;
    end
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    match_idx_r  <= match_idx_nxt;
    match_refs_r <= match_refs_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    zero_r       <= zero_nxt;
    zero_idx_r   <= zero_idx_nxt;
    mask_r       <= mask_nxt;
    ostatus_r    <= ostatus_nxt;
    oslot_r      <= oslot_nxt;
    owr_r        <= owr_nxt;
    oinv_r       <= oinv_nxt;
    otword_r     <= otword_nxt;
    olock_r      <= olock_nxt;
    omask_r      <= omask_nxt;
  end

  // finish reports the requested slot number as given, even out of range
  assign slot_ext = (op_r == OP_FINISH) ? sin_ext : EXT_W'(oslot_r);
  assign mask_ext = MASK_W'(omask_r);

  assign out_valid          = ovalid_r;
  assign out_status         = ostatus_r;
  assign out_slot_out       = slot_ext[2:0];
  assign out_write_table    = owr_r;
  assign out_invalidate_old = oinv_r;
  assign out_table_word     = otword_r;
  assign out_lock_region    = olock_r;
  assign out_slot_mask      = mask_ext[7:0];

endmodule

`default_nettype wire

### hdl/asa_slot_table.sv
// asa_slot_table: flop-based slot table (valid, owner space id, ref count).
// One read index, one write port. Uses asa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asa_slot_table
  import asa_pkg::*;
#(
  parameter int unsigned SLOTS    = 8,
  parameter int unsigned IDX_W    = 3,
  parameter int unsigned REF_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [IDX_W-1:0]    rd_idx,
  output      logic                rd_valid,
  output      logic [SPACE_W-1:0]  rd_space,
  output      logic [REF_BITS-1:0] rd_refs,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_idx,
  input  wire logic                wr_valid,
  input  wire logic [SPACE_W-1:0]  wr_space,
  input  wire logic [REF_BITS-1:0] wr_refs
);

  logic [SLOTS-1:0]    valid_r;
  logic [SPACE_W-1:0]  space_r [SLOTS];
  logic [REF_BITS-1:0] refs_r  [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        space_r[i] <= '0;
        refs_r[i]  <= '0;
      end
    end else if (wr_en) begin
      valid_r[wr_idx] <= wr_valid;
      space_r[wr_idx] <= wr_space;
      refs_r[wr_idx]  <= wr_refs;
    end
  end

  assign rd_valid = valid_r[rd_idx];
  assign rd_space = space_r[rd_idx];
  assign rd_refs  = refs_r[rd_idx];

endmodule

`default_nettype wire

### hdl/asa_log_unit.sv
// asa_log_unit: iterative ceil(log2(pages)) of a flush length, one bit per cycle.
// Uses asa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asa_log_unit
  import asa_pkg::*;
#(
  parameter int unsigned PAGE_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire logic [LENGTH_W-1:0] length,
  output      log_stat_t           stat
);

  logic [LENGTH_W-1:0] pages;
  logic [LENGTH_W-1:0] x_r, x_nxt;
  logic [CODE_W-1:0]   cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;

  // ceil(log2(p)) equals the bit length of p-1; zero pages give zero
  assign pages = length >> PAGE_BITS;

  always_comb begin
    x_nxt    = x_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (load) begin
      x_nxt    = (pages == '0) ? '0 : pages - LENGTH_W'(1);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        x_nxt   = x_r >> 1;
        cnt_nxt = cnt_r + CODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r   <= x_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.code = cnt_r;

endmodule

`default_nettype wire

### hdl/asa_checker.sv
// asa_checker: port-level assertions for address_slot_allocator, bound to the top.
// Uses asa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asa_checker
  import asa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [2:0]        out_status,
  input wire logic              out_write_table,
  input wire logic              out_invalidate_old,
  input wire logic [WORD_W-1:0] out_lock_region
);

  // a taken request always makes the block busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // the result strobe never comes back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_table |-> out_status == ST_FREE || out_status == ST_EVICTED)
    else $error("table write without new slot");

  a_inv_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalidate_old |-> out_status == ST_EVICTED && out_write_table)
    else $error("invalidate without eviction");

  a_lock_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lock_region != '0 |-> out_status == ST_DONE)
    else $error("lock region on a failed request");

endmodule

bind address_slot_allocator asa_checker u_asa_checker (.*);

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for address_slot_allocator (slot table, flush lock word).
// Depends on asa_pkg and hdl/address_slot_allocator.sv; a scoreboard class predicts
// every result from its own copy of the slot table.
`timescale 1ns / 1ps

module tb_top
  import asa_pkg::*;
;

  localparam int unsigned NSLOTS       = 8;
  localparam int unsigned PG_LOG2      = 12;
  localparam int unsigned REF_LIMIT    = 255;
  localparam int unsigned RAND_ITEMS   = 1000;
  localparam int unsigned BURST_AT     = 500;
  localparam int unsigned BURST_LEN    = 260;
  localparam int unsigned MAX_GAP      = 60;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned MAX_CYCLES   = 400000;

  typedef struct packed {
    logic [1:0]          op;
    logic [SPACE_W-1:0]  space;
    logic                lost;
    logic [2:0]          slot;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic [WORD_W-1:0]   entry;
  } slot_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        slot;
    logic              wr;
    logic              inv;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] lock;
    logic [7:0]        mask;
  } slot_rsp_t;

  class slot_scoreboard;
    bit               valid [NSLOTS];
    bit [SPACE_W-1:0] owner [NSLOTS];
    int unsigned      refs [NSLOTS];
    slot_rsp_t        expected_q[$];
    int unsigned      errors;
    int unsigned      requests;
    int unsigned      checked;
    int unsigned      status_seen [8];

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        valid[i] = 1'b0;
        owner[i] = '0;
        refs[i]  = 0;
      end
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      errors   = 0;
      requests = 0;
      checked  = 0;
    endfunction

    function int find_owner(logic [SPACE_W-1:0] id);
      for (int i = 0; i < NSLOTS; i++)
        if (valid[i] && owner[i] == id) return i;
      return -1;
    endfunction

    // ceil(log2(pages)) + offset, pages of 0 or 1 give a log of 0
    function logic [WORD_W-1:0] region_code(logic [LENGTH_W-1:0] length);
      logic [LENGTH_W-1:0] pages;
      int unsigned lg;
      pages = length >> PG_LOG2;
      lg = 0;
      while (lg < 63 && (65'd1 << lg) < pages) lg++;
      return WORD_W'(lg) + REGION_OFFSET;
    endfunction

    function void note_request(slot_req_t r);
      slot_rsp_t rsp;
      int k;
      rsp = '0;
      requests++;
      case (r.op)
        OP_ASSIGN: begin
          k = find_owner(r.space);
          if (r.lost) begin
            rsp.status = ST_LOST;
          end else if (k >= 0) begin
            rsp.slot = 3'(k);
            if (refs[k] >= REF_LIMIT) begin
              rsp.status = ST_REFS_FULL;
            end else begin
              refs[k]++;
              rsp.status = ST_REUSED;
            end
          end else begin
            for (int i = 0; i < NSLOTS; i++)
              if (k < 0 && !valid[i]) k = i;
            if (k >= 0) begin
              rsp.status = ST_FREE;
            end else begin
              for (int i = 0; i < NSLOTS; i++)
                if (k < 0 && refs[i] == 0) k = i;
              if (k >= 0) begin
                rsp.status = ST_EVICTED;
                rsp.inv = 1'b1;
              end
            end
            if (k >= 0) begin
              valid[k] = 1'b1;
              owner[k] = r.space;
              refs[k]  = 1;
              rsp.slot = 3'(k);
              rsp.wr   = 1'b1;
              rsp.word = r.entry;
            end else begin
              rsp.status = ST_NONE;
            end
          end
        end
        OP_FINISH: begin
          rsp.slot = r.slot;
          if (r.slot < NSLOTS && refs[r.slot] != 0) begin
            refs[r.slot]--;
            rsp.status = ST_DONE;
          end else begin
            rsp.status = ST_UNMAPPED;
          end
        end
        OP_RELEASE: begin
          // clears even slots that still hold references
          for (int i = 0; i < NSLOTS; i++) begin
            if (valid[i] && owner[i] == r.space) begin
              valid[i] = 1'b0;
              owner[i] = '0;
              refs[i]  = 0;
              rsp.mask[i] = 1'b1;
            end
          end
          rsp.status = ST_DONE;
        end
        default: begin
          k = find_owner(r.space);
          if (k >= 0) begin
            rsp.slot   = 3'(k);
            rsp.status = ST_DONE;
            rsp.lock   = {{(WORD_W-START_W){1'b0}}, r.start} | region_code(r.length);
          end else begin
            rsp.status = ST_UNMAPPED;
          end
        end
      endcase
      expected_q = {expected_q, rsp};
    endfunction

    task report(string msg);
      $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got %h want %h (result %0d)", name, got, want, checked));
    endtask

    task check_result(slot_rsp_t got);
      slot_rsp_t want;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = expected_q.pop_front();
        status_seen[want.status]++;
        compare_field("status", WORD_W'(got.status), WORD_W'(want.status));
        compare_field("slot_out", WORD_W'(got.slot), WORD_W'(want.slot));
        compare_field("write_table", WORD_W'(got.wr), WORD_W'(want.wr));
        compare_field("invalidate_old", WORD_W'(got.inv), WORD_W'(want.inv));
        compare_field("table_word", got.word, want.word);
        compare_field("lock_region", got.lock, want.lock);
        compare_field("slot_mask", WORD_W'(got.mask), WORD_W'(want.mask));
        checked++;
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_operation = '0;
  logic [SPACE_W-1:0]  in_space_id = '0;
  logic                in_space_lost = 1'b0;
  logic [2:0]          in_slot_in = '0;
  logic [START_W-1:0]  in_range_start = '0;
  logic [LENGTH_W-1:0] in_range_length = '0;
  logic [WORD_W-1:0]   in_table_entry = '0;
  logic                out_valid;
  logic [2:0]          out_status;
  logic [2:0]          out_slot_out;
  logic                out_write_table;
  logic                out_invalidate_old;
  logic [WORD_W-1:0]   out_table_word;
  logic [WORD_W-1:0]   out_lock_region;
  logic [7:0]          out_slot_mask;

  slot_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned idle_pct = 11;
  logic [SPACE_W-1:0] id_pool [12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                       16'h5A5A, 16'hA5A5, 16'h00FF, 16'hFF00,
                                       16'h1234, 16'h7FFF, 16'h0100, 16'hFEDC};

  address_slot_allocator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_space_id        (in_space_id),
    .in_space_lost      (in_space_lost),
    .in_slot_in         (in_slot_in),
    .in_range_start     (in_range_start),
    .in_range_length    (in_range_length),
    .in_table_entry     (in_table_entry),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_write_table    (out_write_table),
    .out_invalidate_old (out_invalidate_old),
    .out_table_word     (out_table_word),
    .out_lock_region    (out_lock_region),
    .out_slot_mask      (out_slot_mask)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result of the edge is checked before a request taken at that same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{status: out_status, slot: out_slot_out,
                          wr: out_write_table, inv: out_invalidate_old,
                          word: out_table_word, lock: out_lock_region,
                          mask: out_slot_mask});
      if (start && !busy)
        sb.note_request('{op: in_operation, space: in_space_id,
                          lost: in_space_lost, slot: in_slot_in,
                          start: in_range_start, length: in_range_length,
                          entry: in_table_entry});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic slot_req_t make_req(logic [1:0] op, logic [SPACE_W-1:0] space,
                                         logic lost, logic [2:0] slot,
                                         logic [START_W-1:0] range_start,
                                         logic [LENGTH_W-1:0] length,
                                         logic [WORD_W-1:0] entry);
    return '{op: op, space: space, lost: lost, slot: slot,
             start: range_start, length: length, entry: entry};
  endfunction

  function automatic slot_req_t random_request();
    slot_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      r.op = OP_ASSIGN;
    else if (pick < 68) r.op = OP_FINISH;
    else if (pick < 82) r.op = OP_FLUSH;
    else                r.op = OP_RELEASE;
    // a small pool of spaces keeps reuse, eviction and full tables frequent
    if ($urandom_range(9) < 8) r.space = id_pool[$urandom_range(11)];
    else                       r.space = SPACE_W'($urandom);
    r.lost = ($urandom_range(9) == 0);
    r.slot = 3'($urandom_range(7));
    r.start = START_W'({$urandom, $urandom});
    if ($urandom_range(3) != 0) r.start[PG_LOG2-1:0] = '0;
    case ($urandom_range(7))
      0:       r.length = '0;
      1:       r.length = LENGTH_W'(1) << START_W;
      default: r.length = LENGTH_W'(START_W'({$urandom, $urandom}) >> $urandom_range(47));
    endcase
    r.entry = {$urandom, $urandom};
    return r;
  endfunction

  task automatic idle_gap();
    int unsigned n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < idle_pct) n++;
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // called right after a rising edge; returns after the edge that takes the request
  task automatic put_request(slot_req_t r);
    in_operation    <= r.op;
    in_space_id     <= r.space;
    in_space_lost   <= r.lost;
    in_slot_in      <= r.slot;
    in_range_start  <= r.start;
    in_range_length <= r.length;
    in_table_entry  <= r.entry;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    idle_gap();
  endtask

  initial begin
    slot_req_t r;
    logic [SPACE_W-1:0] burst_id;
    logic [WORD_W-1:0] ones;
    ones = '1;
    burst_id = 16'h2468;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: flush and finish find nothing, lost space changes nothing
    put_request(make_req(OP_FLUSH, 16'h0000, 1'b0, 3'd0, '0, '0, '0));
    put_request(make_req(OP_FINISH, 16'h0000, 1'b0, 3'd0, '0, '0, '0));
    put_request(make_req(OP_FINISH, 16'hFFFF, 1'b1, 3'd7, '1, '1, ones));
    put_request(make_req(OP_ASSIGN, 16'hFFFF, 1'b1, 3'd7, '1, '1, ones));
    // fill every slot, reusing slot 0 on the way
    put_request(make_req(OP_ASSIGN, 16'h0000, 1'b0, 3'd0, '0, '0, '0));
    put_request(make_req(OP_ASSIGN, 16'hFFFF, 1'b0, 3'd7, '1, '1, ones));
    put_request(make_req(OP_ASSIGN, 16'h0000, 1'b0, 3'd0, '0, '0, 64'h1));
    for (int i = 1; i <= 6; i++)
      put_request(make_req(OP_ASSIGN, SPACE_W'(i), 1'b0, 3'(i), '0, '0,
                           {$urandom, $urandom}));
    // all slots referenced: nothing free
    put_request(make_req(OP_ASSIGN, 16'h0007, 1'b0, 3'd0, '0, '0, 64'hDEAD_BEEF));
    // drop the only reference on slot 1, then evict its owner
    put_request(make_req(OP_FINISH, 16'h0000, 1'b0, 3'd1, '0, '0, '0));
    put_request(make_req(OP_ASSIGN, 16'h0008, 1'b0, 3'd0, '0, '0, 64'hA5A5_5A5A_0F0F_F0F0));
    // flush: zero length, widest range, unaligned start, odd page count
    put_request(make_req(OP_FLUSH, 16'h0000, 1'b0, 3'd0, '0, '0, '0));
    put_request(make_req(OP_FLUSH, 16'h0008, 1'b0, 3'd0, '1, LENGTH_W'(1) << START_W, '0));
    put_request(make_req(OP_FLUSH, 16'h0000, 1'b0, 3'd0, 48'h123, 49'h1001, '0));
    put_request(make_req(OP_FLUSH, 16'h0003, 1'b0, 3'd0, 48'hABCD_E000, 49'h3000, '0));
    put_request(make_req(OP_FLUSH, 16'h0004, 1'b0, 3'd0, 48'h1000, '1 >> 1, '0));
    // release with references left, and release of an unmapped space
    put_request(make_req(OP_RELEASE, 16'h0000, 1'b0, 3'd0, '0, '0, '0));
    put_request(make_req(OP_RELEASE, 16'h1234, 1'b0, 3'd0, '0, '0, '0));
    put_request(make_req(OP_FINISH, 16'h0000, 1'b0, 3'd7, '0, '0, '0));
    put_request(make_req(OP_FINISH, 16'h0000, 1'b0, 3'd0, '0, '0, '0));

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n < RAND_ITEMS / 3)          idle_pct = 11;
      else if (n < 2 * RAND_ITEMS / 3) idle_pct = 88;
      else                             idle_pct = 0;
      r = random_request();
      // one long run of assigns on one space drives its count to saturation
      if (n == BURST_AT && sb.valid[0]) burst_id = sb.owner[0];
      if (n >= BURST_AT && n < BURST_AT + BURST_LEN) begin
        r.op = OP_ASSIGN;
        r.lost = 1'b0;
        r.space = burst_id;
      end
      put_request(r);
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests, %0d results checked, %0d mismatches",
             sb.requests, sb.checked, sb.errors);
    $display("tb_top: reused %0d free %0d evicted %0d none %0d lost %0d done %0d unmapped %0d full %0d",
             sb.status_seen[ST_REUSED], sb.status_seen[ST_FREE], sb.status_seen[ST_EVICTED],
             sb.status_seen[ST_NONE], sb.status_seen[ST_LOST], sb.status_seen[ST_DONE],
             sb.status_seen[ST_UNMAPPED], sb.status_seen[ST_REFS_FULL]);
    if (sb.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

### sim.f
hdl/asa_pkg.sv
hdl/asa_slot_table.sv
hdl/asa_log_unit.sv
hdl/address_slot_allocator.sv
hdl/asa_checker.sv
bench/tb_top.sv
